// ===== hw/rtl/frame_crc16_generate_check_top_macros.svh =====
// Assertion macros used by the checker file of the frame CRC-16 block.
`ifndef FRAME_CRC16_GENERATE_CHECK_TOP_MACROS_SVH
`define FRAME_CRC16_GENERATE_CHECK_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define FCRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define FCRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fcrc_pkg.sv =====
// Types, codes and the byte-wide CRC-16 update for the frame CRC-16 block.
package fcrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic       KIND_CRC    = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] crc_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // Eight CRC steps, data bits taken least significant first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = data[i] ^ crc[15];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/frame_crc16_generate_check_top.sv =====
// Top level of the frame CRC-16 generator and checker.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   input    | i_in_valid / o_in_stall    | i_data_byte, i_frame_start
//   result   | o_out_valid / i_out_stall  | o_result_kind, o_crc_byte,
//            |                            | o_check_status, o_last_of_run
//   config   | i_cfg_valid / o_cfg_ready  | i_cfg_check_mode
//
// A word is taken into the input register, processed and its results land in a
// four-entry result queue; one word per cycle is accepted while the input is not stalled.
// A word's first result is offered once the word has passed the input register and the queue;
// generate mode puts two results per frame end into the queue, which drains one per unstalled cycle.
// The input stalls only while the queue has fewer than two free entries.
// Reset is synchronous and clears the frame state, the queue and check_mode.
module frame_crc16_generate_check_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_result_kind,
    output logic [7:0] o_crc_byte,
    output logic [1:0] o_check_status,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_check_mode
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_start;

    logic              room;
    logic              fire;
    logic              accept;
    fcrc_pkg::t_push   push;
    fcrc_pkg::t_result result;

    assign fire        = r_in_valid && room;
    assign o_in_stall  = r_in_valid && !room;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data  <= i_data_byte;
            r_in_start <= i_frame_start;
        end
    end

    fcrc_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_check_mode (i_cfg_check_mode),
        .i_fire           (fire),
        .i_data_byte      (r_in_data),
        .i_frame_start    (r_in_start),
        .o_push           (push)
    );

    fcrc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (result)
    );

    assign o_result_kind  = result.kind;
    assign o_crc_byte     = result.crc_byte;
    assign o_check_status = result.status;
    assign o_last_of_run  = result.last;

endmodule

// ===== hw/rtl/fcrc_core.sv =====
// Frame tracking, CRC update and result forming for one word per cycle while i_fire is high.
module fcrc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_check_mode,
    input  logic               i_fire,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    output fcrc_pkg::t_push    o_push
);

    logic        r_check_mode;
    logic [15:0] r_crc;
    logic [7:0]  r_pos;
    logic [7:0]  r_len;
    logic        r_active;
    logic [7:0]  r_first;

    logic [15:0] n_crc;
    logic [7:0]  n_pos;
    logic [7:0]  n_len;
    logic        n_active;
    logic [7:0]  n_first;

    logic [15:0] crc_in;
    logic [15:0] crc_fed;
    logic [7:0]  data_len;
    logic [7:0]  pos_inc;
    logic        crc_ok;
    fcrc_pkg::t_result crc_lo;
    fcrc_pkg::t_result crc_hi;
    fcrc_pkg::t_result stat;

    assign crc_in   = i_frame_start ? 16'd0 : r_crc;
    assign crc_fed  = fcrc_pkg::crc_feed(crc_in, i_data_byte);
    assign data_len = r_len - 8'd2;
    assign pos_inc  = r_pos + 8'd1;
    assign crc_ok   = (r_first == r_crc[7:0]) && (i_data_byte == r_crc[15:8]);

    assign crc_lo = '{kind: fcrc_pkg::KIND_CRC, crc_byte: crc_fed[7:0],
                      status: fcrc_pkg::STATUS_OK, last: 1'b0};
    assign crc_hi = '{kind: fcrc_pkg::KIND_CRC, crc_byte: crc_fed[15:8],
                      status: fcrc_pkg::STATUS_OK, last: 1'b1};

    always_comb begin
        n_crc    = r_crc;
        n_pos    = r_pos;
        n_len    = r_len;
        n_active = r_active;
        n_first  = r_first;
        stat     = '{kind: fcrc_pkg::KIND_STATUS, crc_byte: 8'd0,
                     status: fcrc_pkg::STATUS_OK, last: 1'b1};
        o_push   = '{count: 2'd0, res0: crc_lo, res1: crc_hi};
        if (i_frame_start) begin
            n_len = i_data_byte;
            if (i_data_byte < 8'd3) begin
                n_active    = 1'b0;
                n_crc       = 16'd0;
                n_pos       = 8'd0;
                stat.status = fcrc_pkg::STATUS_SHORT;
                o_push      = '{count: 2'd1, res0: stat, res1: crc_hi};
            end else begin
                n_active = 1'b1;
                n_crc    = crc_fed;
                n_pos    = 8'd1;
                if (i_data_byte == 8'd3 && !r_check_mode) begin
                    n_active     = 1'b0;
                    o_push.count = 2'd2;
                end
            end
        end else if (r_active) begin
            if (r_pos < data_len) begin
                n_crc = crc_fed;
                n_pos = pos_inc;
                if (pos_inc == data_len && !r_check_mode) begin
                    n_active     = 1'b0;
                    o_push.count = 2'd2;
                end
            end else if (!r_check_mode) begin
                n_active = 1'b0;
            end else if (r_pos == data_len) begin
                n_first = i_data_byte;
                n_pos   = pos_inc;
            end else begin
                n_active    = 1'b0;
                stat.status = crc_ok ? fcrc_pkg::STATUS_OK : fcrc_pkg::STATUS_BAD_CRC;
                o_push      = '{count: 2'd1, res0: stat, res1: crc_hi};
            end
        end
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b0;
            r_crc        <= 16'd0;
            r_pos        <= 8'd0;
            r_len        <= 8'd0;
            r_active     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_check_mode <= i_cfg_check_mode;
            end
            if (i_fire) begin
                r_crc    <= n_crc;
                r_pos    <= n_pos;
                r_len    <= n_len;
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_first <= n_first;
        end
    end

endmodule

// ===== hw/rtl/fcrc_outq.sv =====
// Result queue that takes up to two results per cycle and delivers one per cycle while not stalled.
module fcrc_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcrc_pkg::t_push    i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output fcrc_pkg::t_result  o_result
);

    fcrc_pkg::t_result r_mem [fcrc_pkg::QUEUE_DEPTH];
    logic [fcrc_pkg::QPTR_W-1:0] r_wr;
    logic [fcrc_pkg::QPTR_W-1:0] r_rd;
    logic [fcrc_pkg::QCNT_W-1:0] r_cnt;
    logic [fcrc_pkg::QPTR_W-1:0] wr_next;
    logic                        pop;

    assign wr_next  = r_wr + fcrc_pkg::QPTR_W'(1);
    assign o_valid  = (r_cnt != '0);
    assign pop      = o_valid && !i_stall;
    assign o_result = r_mem[r_rd];
    assign o_room   = (r_cnt <= fcrc_pkg::QCNT_W'(fcrc_pkg::QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + fcrc_pkg::QPTR_W'(i_push.count);
            r_cnt <= r_cnt + fcrc_pkg::QCNT_W'(i_push.count)
                     - fcrc_pkg::QCNT_W'(pop);
            if (pop) begin
                r_rd <= r_rd + fcrc_pkg::QPTR_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/fcrc_checker.sv =====
// Port-level checker for the frame CRC-16 block and its bind statement.
`include "frame_crc16_generate_check_top_macros.svh"

module fcrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_data_byte,
    input logic       i_frame_start,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_result_kind,
    input logic [7:0] o_crc_byte,
    input logic [1:0] o_check_status,
    input logic       o_last_of_run,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       i_cfg_check_mode
);

    `FCRC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result word dropped while stalled")
    `FCRC_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable({o_result_kind, o_crc_byte, o_check_status, o_last_of_run}), "result word changed while stalled")
    `FCRC_ASSERT(a_status_last, o_out_valid && o_result_kind == fcrc_pkg::KIND_STATUS |-> o_last_of_run && o_crc_byte == 8'd0 && o_check_status != 2'd3, "malformed status word")
    `FCRC_ASSERT(a_crc_status_zero, o_out_valid && o_result_kind == fcrc_pkg::KIND_CRC |-> o_check_status == fcrc_pkg::STATUS_OK, "CRC word carries a status")
    `FCRC_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && !o_in_stall, "block not idle after reset")

endmodule

bind frame_crc16_generate_check_top fcrc_checker u_fcrc_checker (.*);

// ===== test/tb_frame_crc16_watch.sv =====
// Result predictor and checker for the frame CRC-16 block, with its CRC helper package.
package fcrc_tb_pkg;

    function automatic logic [15:0] crc16_add_byte(input logic [15:0] acc,
                                                   input logic [7:0]  b);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (b[k] ^ r[15]) begin
                r = {r[14:0], 1'b0} ^ fcrc_pkg::CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

module tb_frame_crc16_watch
    import fcrc_pkg::*;
    import fcrc_tb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_result_kind,
    input  logic [7:0] i_crc_byte,
    input  logic [1:0] i_check_status,
    input  logic       i_last_of_run,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_check_mode,
    output int         o_mismatches,
    output int         o_results_due,
    output int         o_crc_bytes,
    output int         o_ok_count,
    output int         o_bad_count,
    output int         o_short_count
);

    logic        check_mode_q;
    logic [15:0] crc_acc;
    logic [7:0]  byte_pos;
    logic [7:0]  frame_len;
    logic [7:0]  first_crc;
    logic        in_frame;
    t_result     results_due[$];

    function automatic t_result make_result(input logic       kind,
                                            input logic [7:0] cb,
                                            input logic [1:0] st,
                                            input logic       last);
        t_result r;
        r.kind     = kind;
        r.crc_byte = cb;
        r.status   = st;
        r.last     = last;
        return r;
    endfunction

    task automatic append_crc_pair();
        results_due.push_back(make_result(KIND_CRC, crc_acc[7:0], STATUS_OK, 1'b0));
        results_due.push_back(make_result(KIND_CRC, crc_acc[15:8], STATUS_OK, 1'b1));
        in_frame = 1'b0;
    endtask

    task automatic predict_word(input logic [7:0] b, input logic s);
        logic [7:0] data_len;
        data_len = frame_len - 8'd2;
        if (s) begin
            in_frame  = 1'b0;
            crc_acc   = 16'h0000;
            byte_pos  = 8'd0;
            frame_len = b;
            if (b < 8'd3) begin
                results_due.push_back(make_result(KIND_STATUS, 8'h00, STATUS_SHORT, 1'b1));
            end else begin
                in_frame = 1'b1;
                crc_acc  = crc16_add_byte(16'h0000, b);
                byte_pos = 8'd1;
                if (byte_pos == b - 8'd2 && !check_mode_q) begin
                    append_crc_pair();
                end
            end
        end else if (in_frame) begin
            if (byte_pos < data_len) begin
                crc_acc  = crc16_add_byte(crc_acc, b);
                byte_pos = byte_pos + 8'd1;
                if (byte_pos == data_len && !check_mode_q) begin
                    append_crc_pair();
                end
            end else if (!check_mode_q) begin
                in_frame = 1'b0;
            end else if (byte_pos == data_len) begin
                first_crc = b;
                byte_pos  = byte_pos + 8'd1;
            end else begin
                in_frame = 1'b0;
                if (first_crc == crc_acc[7:0] && b == crc_acc[15:8]) begin
                    results_due.push_back(make_result(KIND_STATUS, 8'h00, STATUS_OK, 1'b1));
                end else begin
                    results_due.push_back(make_result(KIND_STATUS, 8'h00, STATUS_BAD_CRC,
                                                      1'b1));
                end
            end
        end
    endtask

    task automatic compare_result();
        t_result got;
        t_result want;
        got = make_result(i_result_kind, i_crc_byte, i_check_status, i_last_of_run);
        if (results_due.size() == 0) begin
            if (o_mismatches < 10) begin
                $display("ERROR at %0t: unexpected result kind=%0d crc=%02h status=%0d last=%0d",
                         $time, got.kind, got.crc_byte, got.status, got.last);
            end
            o_mismatches++;
        end else begin
            want = results_due.pop_front();
            if (got !== want) begin
                if (o_mismatches < 10) begin
                    $display("ERROR at %0t: expected kind=%0d crc=%02h status=%0d last=%0d",
                             $time, want.kind, want.crc_byte, want.status, want.last);
                    $display("              actual   kind=%0d crc=%02h status=%0d last=%0d",
                             got.kind, got.crc_byte, got.status, got.last);
                end
                o_mismatches++;
            end
            if (want.kind == KIND_CRC) begin
                o_crc_bytes++;
            end else if (want.status == STATUS_OK) begin
                o_ok_count++;
            end else if (want.status == STATUS_BAD_CRC) begin
                o_bad_count++;
            end else begin
                o_short_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            check_mode_q = 1'b0;
            crc_acc      = 16'h0000;
            byte_pos     = 8'd0;
            frame_len    = 8'd0;
            first_crc    = 8'd0;
            in_frame     = 1'b0;
            results_due.delete();
            o_mismatches  = 0;
            o_crc_bytes   = 0;
            o_ok_count    = 0;
            o_bad_count   = 0;
            o_short_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                check_mode_q = i_cfg_check_mode;
            end
            if (i_out_valid && !i_out_stall) begin
                compare_result();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_word(i_data_byte, i_frame_start);
            end
        end
        o_results_due = results_due.size();
    end

endmodule

// ===== test/tb_frame_crc16_generate_check_top.sv =====
// Stimulus and verdict for the frame CRC-16 generator and checker.
module tb_frame_crc16_generate_check_top;
    import fcrc_pkg::*;
    import fcrc_tb_pkg::*;

    localparam int WORD_TARGET   = 650;
    localparam int HOLD_CYCLES   = 48;
    localparam int SETTLE_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_frame_start;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_result_kind;
    logic [7:0] o_crc_byte;
    logic [1:0] o_check_status;
    logic       o_last_of_run;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_check_mode;

    int   mismatches;
    int   due;
    int   crc_bytes;
    int   ok_count;
    int   bad_count;
    int   short_count;
    int   words_sent;
    int   mode_writes;
    int   holds_requested;
    int   holds_done;
    bit   gaps_on;
    logic mode_now;

    frame_crc16_generate_check_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_crc_byte      (o_crc_byte),
        .o_check_status  (o_check_status),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_check_mode(i_cfg_check_mode)
    );

    tb_frame_crc16_watch i_watch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_frame_start   (i_frame_start),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_result_kind   (o_result_kind),
        .i_crc_byte      (o_crc_byte),
        .i_check_status  (o_check_status),
        .i_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_check_mode(i_cfg_check_mode),
        .o_mismatches    (mismatches),
        .o_results_due   (due),
        .o_crc_bytes     (crc_bytes),
        .o_ok_count      (ok_count),
        .o_bad_count     (bad_count),
        .o_short_count   (short_count)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic send_word(input logic [7:0] b, input logic s);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic hold_input_until_empty();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (due != 0);
        @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        hold_input_until_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_check_mode <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mode_now = m;
        mode_writes++;
    endtask

    task automatic send_frame(input logic [7:0] count, input int data_words,
                              input int crc_words, input logic spoil);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = crc16_add_byte(16'h0000, count);
        send_word(count, 1'b1);
        if (count < 8'd3) begin
            return;
        end
        for (int k = 0; k < data_words; k++) begin
            b   = 8'($urandom);
            crc = crc16_add_byte(crc, b);
            send_word(b, 1'b0);
        end
        if (spoil) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        if (crc_words > 0) begin
            send_word(crc[7:0], 1'b0);
        end
        if (crc_words > 1) begin
            send_word(crc[15:8], 1'b0);
        end
    endtask

    task automatic random_frame();
        int         pick;
        int         full;
        int         part;
        logic [7:0] cnt;
        pick = $urandom_range(0, 19);
        cnt  = ($urandom_range(0, 99) == 0) ? 8'd255 : 8'($urandom_range(3, 20));
        full = int'(cnt) - 3;
        if (pick < 14) begin
            send_frame(cnt, full, mode_now ? 2 : 0, mode_now && $urandom_range(0, 2) == 0);
        end else if (pick < 16) begin
            send_word(8'($urandom_range(0, 2)), 1'b1);
        end else if (pick < 18) begin
            cnt  = 8'($urandom_range(3, 12));
            full = int'(cnt) - 3;
            part = $urandom_range(0, full);
            send_frame(cnt, part, (part == full) ? $urandom_range(0, 2) : 0,
                       $urandom_range(0, 1) == 1);
        end else begin
            repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done < holds_requested) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                holds_done++;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #(12 * 300000);
        $display("Timed out with %0d results outstanding", due);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [15:0] c;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_data_byte      <= 8'h00;
        i_frame_start    <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_check_mode <= 1'b0;
        words_sent       = 0;
        mode_writes      = 0;
        holds_requested  = 0;
        holds_done       = 0;
        gaps_on          = 1'b1;
        mode_now         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(1'b0);
        send_word(8'd0, 1'b1);
        send_word(8'd1, 1'b1);
        send_word(8'd2, 1'b1);
        send_word(8'd3, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'd5, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'd6, 1'b1);
        send_word(8'h55, 1'b0);
        send_word(8'd4, 1'b1);
        send_word(8'hAA, 1'b0);
        send_word(8'h12, 1'b0);

        // The mode changes from generate to check partway through a frame.
        send_word(8'd6, 1'b1);
        send_word(8'h01, 1'b0);
        write_mode(1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'hFE, 1'b0);
        c = crc16_add_byte(16'h0000, 8'd6);
        c = crc16_add_byte(c, 8'h01);
        c = crc16_add_byte(c, 8'h80);
        c = crc16_add_byte(c, 8'hFE);
        send_word(c[7:0], 1'b0);
        send_word(c[15:8], 1'b0);

        send_frame(8'd3, 0, 2, 1'b0);
        send_frame(8'd4, 1, 2, 1'b1);
        send_word(8'd2, 1'b1);

        // Switching back to generate after the data part drops the frame.
        send_word(8'd5, 1'b1);
        send_word(8'hA5, 1'b0);
        send_word(8'h3C, 1'b0);
        send_word(8'h00, 1'b0);
        write_mode(1'b0);
        send_word(8'h77, 1'b0);

        write_mode(1'b1);
        send_frame(8'd255, 252, 2, 1'b0);

        while (words_sent < WORD_TARGET || holds_requested == 0) begin
            write_mode(1'($urandom_range(0, 1)));
            if (holds_requested == 0 && words_sent > 400) begin
                write_mode(1'b0);
                holds_requested++;
                repeat (16) send_word(8'd3, 1'b1);
                hold_input_until_empty();
            end
            if (words_sent > WORD_TARGET - 120) begin
                gaps_on = 1'b0;
            end
            repeat ($urandom_range(3, 8)) random_frame();
        end

        gaps_on = 1'b0;
        hold_input_until_empty();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d input words over %0d mode writes, with one long result hold.",
                 words_sent, mode_writes);
        $display("Checked %0d CRC bytes and %0d ok, %0d bad-CRC, %0d short-count statuses.",
                 crc_bytes, ok_count, bad_count, short_count);
        if (mismatches == 0 && due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fcrc_pkg.sv
hw/rtl/fcrc_core.sv
hw/rtl/fcrc_outq.sv
hw/rtl/frame_crc16_generate_check_top.sv
hw/rtl/fcrc_checker.sv
test/tb_frame_crc16_watch.sv
test/tb_frame_crc16_generate_check_top.sv
